>>> rtl/core/dorbt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DRAM open-row bank timing: shared package
// Widths, register codes, word types and the saturating time add.
// ----------------------------------------------------------------------------
package dorbt_pkg;

  localparam int BANK_COUNT       = 16;
  localparam int BANK_BITS        = $clog2(BANK_COUNT);
  localparam int MAX_ACCESS_BYTES = 256;
  localparam int ADDR_W           = 32;
  localparam int ROW_W            = 32;
  localparam int SIZE_W           = 9;
  localparam int TIME_W           = 48;
  localparam int LAT_W            = 32;
  localparam int DELAY_W          = 16;
  localparam int KSUM_W           = DELAY_W + 2;
  localparam int LOG2_W           = 3;
  localparam int SHIFT_W          = 5;
  localparam int CFG_IDX_W        = 3;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEND      = 3'd0,
    CFG_RETURN    = 3'd1,
    CFG_PRECHARGE = 3'd2,
    CFG_CLOSED    = 3'd3,
    CFG_CONFLICT  = 3'd4,
    CFG_BUS_LOG2  = 3'd5,
    CFG_ROW_SHIFT = 3'd6
  } cfg_idx_e;

  // request modes
  typedef enum logic {
    MODE_ACCESS = 1'b0,
    MODE_CLEAR  = 1'b1
  } mode_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_WRITE,
    ST_MAX,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic [SIZE_W-1:0] size_bytes;
    logic [TIME_W-1:0] start_time;
  } req_t;

  typedef struct packed {
    logic [LAT_W-1:0] latency;
    logic             size_error;
  } rsp_t;

  // one bank entry of the state memory
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [TIME_W-1:0] ready;
  } bank_ent_t;

  localparam int ENT_W = $bits(bank_ent_t);

  // add a delay sum to a time, clamp at the largest time
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [KSUM_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {{(TIME_W+1-KSUM_W){1'b0}}, b};
    return sum[TIME_W] ? {TIME_W{1'b1}} : sum[TIME_W-1:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/core/dram_bank_open_row_timing_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// DRAM open-row bank timing core
// Predicts access latency from per-bank open rows and ready times.
// ----------------------------------------------------------------------------
// A request word is taken when start_i is high and busy_o is low. A clear
// word or a word with a bad size gives its result in the cycle after it is
// taken. A timed access of n = size_bytes >> bus_width_log2 chunks walks its
// chunks in turn: each chunk does a read, an update and a write back of its
// bank entry in the bank state memory (ST_READ, ST_CALC, ST_WRITE), and then
// ST_MAX and ST_OUT settle the latest completion and the latency. The result
// is on rsp_o for one cycle with rsp_valid_o high and cannot be held off; a
// new request may be taken in that same cycle. There is no clearing pass
// after reset. Configuration writes are always taken.
// ----------------------------------------------------------------------------
module dram_bank_open_row_timing_core
  import dorbt_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire req_t                 req_i,
  output logic                      rsp_valid_o,
  output rsp_t                      rsp_o,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [DELAY_W-1:0]   cfg_data_i
);

  // configuration registers
  logic [DELAY_W-1:0] send_q, return_q, precharge_q, closed_q, conflict_q;
  logic [LOG2_W-1:0]  bus_log2_q;
  logic [SHIFT_W-1:0] row_shift_q;

  // sequencer and bank flags
  state_e                state_q, state_d;
  logic [BANK_COUNT-1:0] open_q;
  logic [BANK_COUNT-1:0] ready_vld_q;
  logic                  upd_q;
  logic                  rsp_valid_q;
  rsp_t                  rsp_q;

  // per-access working registers
  logic [ADDR_W-1:0]    addr_q, inc_q;
  logic [TIME_W-1:0]    t_q, start_q, last_q, base_q, done_q;
  logic [KSUM_W-1:0]    k_closed_q, k_hit_q, k_conf_q, k_q;
  logic [DELAY_W-1:0]   ret_q;
  logic [SIZE_W-1:0]    cnt_q;
  logic [BANK_BITS-1:0] bank_q, prev_bank_q;
  logic [ROW_W-1:0]     row_q;
  logic                 same_q, have_prev_q;

  // combinational nets
  logic                 accept, is_clear, size_bad, ram_re, ram_we;
  logic [SIZE_W-1:0]    chunk_mask;
  logic [ADDR_W-1:0]    line;
  logic [BANK_BITS-1:0] line_bank;
  bank_ent_t            rd_ent, wr_ent;
  logic [TIME_W-1:0]    ready_t, max_rt, base_d, r_d, diff;
  logic [KSUM_W-1:0]    k_d;

  assign cfg_ready_o = 1'b1;
  assign busy_o      = (state_q != ST_IDLE);
  assign accept      = start_i && !busy_o;
  assign is_clear    = (req_i.mode == MODE_CLEAR);

  // check the request size: not zero, at most MAX_ACCESS_BYTES, whole chunks
  assign chunk_mask = (SIZE_W'(1) << bus_log2_q) - SIZE_W'(1);
  assign size_bad   = (req_i.size_bytes == '0) ||
                      (req_i.size_bytes > SIZE_W'(MAX_ACCESS_BYTES)) ||
                      ((req_i.size_bytes & chunk_mask) != '0);

  // split the chunk address into bank and row
  assign line      = addr_q >> row_shift_q;
  assign line_bank = line[BANK_BITS-1:0];

  // pick the base time and the delay sum for the chunk
  assign ready_t = ready_vld_q[bank_q] ? rd_ent.ready : '0;
  assign max_rt  = (ready_t > t_q) ? ready_t : t_q;

  always_comb begin
    if (!open_q[bank_q]) begin
      base_d = t_q;
      k_d    = k_closed_q;
    end else if (rd_ent.row == row_q) begin
      if (same_q) begin
        base_d = ready_t;
        k_d    = {{(KSUM_W-DELAY_W){1'b0}}, ret_q};
      end else begin
        base_d = max_rt;
        k_d    = k_hit_q;
      end
    end else begin
      base_d = max_rt;
      k_d    = k_conf_q;
    end
  end

  assign r_d         = sat_add(base_q, k_q);
  assign wr_ent.row   = row_q;
  assign wr_ent.ready = r_d;
  assign diff         = last_q - start_q;

  // bank state memory
  dorbt_ram #(
    .WIDTH(ENT_W),
    .DEPTH(BANK_COUNT)
  ) u_bank_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(bank_q),
    .wdata_i(wr_ent),
    .re_i   (ram_re),
    .raddr_i(line_bank),
    .rdata_o(rd_ent)
  );

  // next state and memory strobes
  always_comb begin
    state_d = state_q;
    ram_re  = 1'b0;
    ram_we  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && !is_clear && !size_bad) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        ram_re  = 1'b1;
        state_d = ST_CALC;
      end
      ST_CALC: begin
        state_d = ST_WRITE;
      end
      ST_WRITE: begin
        ram_we  = 1'b1;
        state_d = (cnt_q == SIZE_W'(1)) ? ST_MAX : ST_READ;
      end
      ST_MAX: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      send_q      <= DELAY_W'(1);
      return_q    <= DELAY_W'(1);
      precharge_q <= DELAY_W'(1);
      closed_q    <= DELAY_W'(1);
      conflict_q  <= DELAY_W'(1);
      bus_log2_q  <= LOG2_W'(3);
      row_shift_q <= SHIFT_W'(11);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_SEND:      send_q      <= cfg_data_i;
        CFG_RETURN:    return_q    <= cfg_data_i;
        CFG_PRECHARGE: precharge_q <= cfg_data_i;
        CFG_CLOSED:    closed_q    <= cfg_data_i;
        CFG_CONFLICT:  conflict_q  <= cfg_data_i;
        CFG_BUS_LOG2:  bus_log2_q  <= cfg_data_i[LOG2_W-1:0];
        CFG_ROW_SHIFT: row_shift_q <= cfg_data_i[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  // track open banks, valid ready times and the result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= '0;
      ready_vld_q <= '0;
      upd_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      upd_q       <= (state_q == ST_WRITE);
      rsp_valid_q <= (state_q == ST_OUT) || (accept && (is_clear || size_bad));
      if (state_q == ST_IDLE && accept && is_clear) begin
        ready_vld_q <= '0;
      end else if (state_q == ST_WRITE) begin
        ready_vld_q[bank_q] <= 1'b1;
        open_q[bank_q]      <= 1'b1;
      end
    end
  end

  // advance the per-access datapath
  always_ff @(posedge clk_i) begin
    if (upd_q && done_q > last_q) begin
      last_q <= done_q;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          addr_q      <= req_i.address;
          inc_q       <= ADDR_W'(1) << bus_log2_q;
          start_q     <= req_i.start_time;
          last_q      <= req_i.start_time;
          t_q         <= sat_add(req_i.start_time,
                                 {{(KSUM_W-DELAY_W){1'b0}}, send_q});
          cnt_q       <= req_i.size_bytes >> bus_log2_q;
          have_prev_q <= 1'b0;
          ret_q       <= return_q;
          k_hit_q     <= KSUM_W'(precharge_q) + KSUM_W'(return_q);
          k_closed_q  <= KSUM_W'(precharge_q) + KSUM_W'(closed_q)
                         + KSUM_W'(return_q);
          k_conf_q    <= KSUM_W'(precharge_q) + KSUM_W'(closed_q)
                         + KSUM_W'(conflict_q) + KSUM_W'(return_q);
          rsp_q.latency    <= '0;
          rsp_q.size_error <= !is_clear && size_bad;
        end
      end
      ST_READ: begin
        bank_q <= line_bank;
        row_q  <= {{BANK_BITS{1'b0}}, line[ADDR_W-1:BANK_BITS]};
        same_q <= have_prev_q && (prev_bank_q == line_bank);
      end
      ST_CALC: begin
        base_q <= base_d;
        k_q    <= k_d;
      end
      ST_WRITE: begin
        done_q      <= r_d;
        prev_bank_q <= bank_q;
        have_prev_q <= 1'b1;
        addr_q      <= addr_q + inc_q;
        cnt_q       <= cnt_q - SIZE_W'(1);
      end
      ST_OUT: begin
        rsp_q.latency    <= (diff[TIME_W-1:LAT_W] != '0) ? {LAT_W{1'b1}}
                                                         : diff[LAT_W-1:0];
        rsp_q.size_error <= 1'b0;
      end
      default: ;
    endcase
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire

>>> rtl/core/dorbt_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dorbt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire
